>>> rtl/core/bld_pkg.sv
// Shared constants and types for the decimal LED digit writer.
package bld_pkg;

  // Display geometry
  localparam int DIGIT_COUNT  = 5;
  localparam int MAX_DECIMALS = 5;
  localparam int DEC_IDX_W    = $clog2(MAX_DECIMALS);

  // Field widths
  localparam int VALUE_W = 16;
  localparam int POINT_W = 3;
  localparam int ADDR_W  = 4;
  localparam int CODE_W  = 8;
  localparam int BCD_W   = 4;

  // Divide by ten through a reciprocal: q = (v * 52429) >> 19, exact for 16-bit v
  localparam logic [VALUE_W-1:0] DIV10_RECIP = 16'd52429;
  localparam int                 DIV10_SHIFT = 19;
  localparam int                 PROD_W      = 2 * VALUE_W;
  localparam int                 QUOT_W      = PROD_W - DIV10_SHIFT;

  // Display codes
  localparam logic [CODE_W-1:0] BLANK_CODE = 8'h0F;
  localparam logic [CODE_W-1:0] POINT_BIT  = 8'h80;
  localparam logic [CODE_W-1:0] ASCII_ZERO = 8'h30;

  // Data handed from one digit cell to the next
  typedef struct packed {
    logic [VALUE_W-1:0]                  value;
    logic [MAX_DECIMALS-1:0][BCD_W-1:0]  digits;
    logic [POINT_W-1:0]                  point;
  } cell_t;

endpackage

>>> rtl/core/bld_if.sv
// Channel interfaces for the input items and the digit writes.
interface bld_in_if;
  import bld_pkg::*;
  logic               valid;
  logic               ready;
  logic [VALUE_W-1:0] value;
  logic [POINT_W-1:0] point_digit;

  modport source (output valid, output value, output point_digit, input ready);
  modport sink   (input valid, input value, input point_digit, output ready);
endinterface

interface bld_out_if;
  import bld_pkg::*;
  logic              valid;
  logic              ready;
  logic [ADDR_W-1:0] digit_address;
  logic [CODE_W-1:0] digit_code;
  logic              last_write;

  modport source (output valid, output digit_address, output digit_code, output last_write,
                  input ready);
  modport sink   (input valid, input digit_address, input digit_code, input last_write,
                  output ready);
endinterface

>>> rtl/core/bld_cell.sv
// One digit cell: peels the least significant decimal digit off the value.
module bld_cell
  import bld_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  en,
  input  logic  prev_valid,
  input  cell_t prev_data,
  output logic  valid,
  output cell_t data
);

  logic [PROD_W-1:0]  prod;
  logic [QUOT_W-1:0]  quot;
  logic [VALUE_W-1:0] quot_x10;
  logic [VALUE_W-1:0] rem_full;
  cell_t              data_next;

  // Split value into value / 10 and value % 10
  always_comb begin
    prod     = PROD_W'(prev_data.value) * PROD_W'(DIV10_RECIP);
    quot     = prod[PROD_W-1:DIV10_SHIFT];
    quot_x10 = VALUE_W'({quot, 3'b000}) + VALUE_W'({quot, 1'b0});
    rem_full = prev_data.value - quot_x10;

    data_next        = prev_data;
    data_next.value  = VALUE_W'(quot);
    // Shift the new digit in at the top; after the last cell it sits at index 0
    data_next.digits = {rem_full[BCD_W-1:0], prev_data.digits[MAX_DECIMALS-1:1]};
  end

  // Advance the chain
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (en) begin
      valid <= prev_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      data <= data_next;
    end
  end

endmodule

>>> rtl/core/bld_serializer.sv
// Output stage: turns one converted value into the sequence of digit writes.
module bld_serializer
  import bld_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       ld_valid,
  input  cell_t      ld_data,
  output logic       take,
  bld_out_if.source  wr
);

  logic                                busy;
  logic [ADDR_W-1:0]                   addr;
  logic [MAX_DECIMALS-1:0][BCD_W-1:0]  digits;
  logic [MAX_DECIMALS-1:0]             shown;
  logic [POINT_W-1:0]                  point;

  logic [MAX_DECIMALS-1:0] shown_next;
  logic                    any_upper;
  logic                    cur_last;
  logic [ADDR_W-1:0]       from_right;
  logic [DEC_IDX_W-1:0]    idx;

  // Mark positions filled by the number: rightmost always, the top nonzero and all below it
  always_comb begin
    any_upper = 1'b0;
    for (int k = MAX_DECIMALS - 1; k >= 0; k--) begin
      any_upper     = any_upper | (ld_data.digits[k] != '0);
      shown_next[k] = any_upper;
    end
    shown_next[0] = 1'b1;
  end

  assign cur_last = (addr == ADDR_W'(DIGIT_COUNT));
  assign take     = !busy || (wr.ready && cur_last);

  // Load a new value, step the address, or drop to idle
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      addr <= ADDR_W'(1);
    end else if (take) begin
      busy <= ld_valid;
      addr <= ADDR_W'(1);
    end else if (wr.ready) begin
      addr <= addr + ADDR_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (take && ld_valid) begin
      digits <= ld_data.digits;
      shown  <= shown_next;
      point  <= ld_data.point;
    end
  end

  // Form the current write
  always_comb begin
    from_right       = ADDR_W'(DIGIT_COUNT) - addr;
    idx              = from_right[DEC_IDX_W-1:0];
    wr.valid         = busy;
    wr.digit_address = addr;
    wr.last_write    = cur_last;
    wr.digit_code    = BLANK_CODE;
    if (from_right < ADDR_W'(MAX_DECIMALS)) begin
      if (shown[idx]) begin
        wr.digit_code = ASCII_ZERO | CODE_W'(digits[idx]);
        if (ADDR_W'(point) == addr) begin
          wr.digit_code = wr.digit_code | POINT_BIT;
        end
      end
    end
  end

endmodule

>>> rtl/core/binary_to_led_digit_writes.sv
// Top level of the decimal LED digit writer: digit cell chain plus write serializer.
//
// Usage:
//   item    : input channel, one beat per number to show (value, point_digit).
//   digit_wr: output channel, DIGIT_COUNT beats per number, addresses 1 (leftmost)
//             up to DIGIT_COUNT, last_write high on the final beat of the number.
//   Leading positions not filled by the number carry blank code 0x0F; filled
//   positions carry ASCII 0x30..0x39, with bit 7 set where the address matches
//   point_digit. Zero shows a single 0 in the rightmost position.
// Path: with the serializer idle, an accepted number walks in order from the first
//   to the last of the five digit cells and is then loaded into the serializer,
//   which presents the first write of the number.
// Rate: the serializer issues one digit write per cycle while digit_wr is ready;
//   the cell chain itself takes a number every cycle while it is not frozen.
// Stall: when digit_wr is not ready the serializer holds its beat; once the last
//   cell holds a number the serializer cannot take, the whole chain freezes and
//   item drops ready until the serializer takes that number.
// Reset: rst (synchronous) empties the cell chain and the serializer; no
//   partial sequence of writes survives it.
module binary_to_led_digit_writes
  import bld_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  bld_in_if.sink    item,
  bld_out_if.source digit_wr
);

  logic              en;
  logic              take;
  logic [MAX_DECIMALS:0] stage_valid;
  cell_t             stage_data [MAX_DECIMALS+1];

  // Freeze only when the last cell is full and the serializer cannot take its number
  assign en         = !stage_valid[MAX_DECIMALS] || take;
  assign item.ready = en;

  // Feed the head of the chain
  always_comb begin
    stage_valid[0]       = item.valid;
    stage_data[0].value  = item.value;
    stage_data[0].digits = '0;
    stage_data[0].point  = item.point_digit;
  end

  // One cell per decimal digit
  for (genvar i = 0; i < MAX_DECIMALS; i++) begin : g_cell
    bld_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .en         (en),
      .prev_valid (stage_valid[i]),
      .prev_data  (stage_data[i]),
      .valid      (stage_valid[i+1]),
      .data       (stage_data[i+1])
    );
  end

  bld_serializer u_serializer (
    .clk      (clk),
    .rst      (rst),
    .ld_valid (stage_valid[MAX_DECIMALS]),
    .ld_data  (stage_data[MAX_DECIMALS]),
    .take     (take),
    .wr       (digit_wr)
  );

endmodule
